// File: sv/gfpt_pkg.sv
`default_nettype none
package gfpt_pkg;

    // Width of the acceleration fields, two's complement.
    localparam int ACCEL_BITS = 12;

    // Indicator scaling: clamp to +/- DOT_LIMIT, then times DOT_SCALE over DOT_LIMIT.
    localparam int DOT_LIMIT  = 150;
    localparam int DOT_SCALE  = 67;
    localparam int DOT_SHIFT  = 21;
    // DOT_SCALE times the rounded-up reciprocal of DOT_LIMIT at DOT_SHIFT fraction bits.
    // Exact floor for every product up to DOT_LIMIT * DOT_SCALE.
    localparam int DOT_RECIP  = (((1 << DOT_SHIFT) + DOT_LIMIT - 1) / DOT_LIMIT) * DOT_SCALE;
    localparam int DOT_CLAMP_BITS = 8;
    localparam int DOT_MULT_BITS  = DOT_CLAMP_BITS + 20;

    localparam int STEP_BITS = $clog2(ACCEL_BITS);

    typedef struct packed {
        logic                         mode;
        logic                         sample_ok;
        logic signed [ACCEL_BITS-1:0] accel_x;
        logic signed [ACCEL_BITS-1:0] accel_y;
    } t_in_word;

    typedef struct packed {
        logic               data_valid;
        logic        [11:0] peak_total;
        logic        [11:0] peak_left;
        logic        [10:0] peak_right;
        logic        [11:0] peak_brake;
        logic signed [7:0]  dot_x;
        logic signed [7:0]  dot_y;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic square;
        logic root_step;
        logic finish;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic quick;     // clear or failed read: no root needed
        logic out_free;  // output register can take a word this cycle
    } t_ctrl_sts;

endpackage
`default_nettype wire

// File: sv/gfpt_ctrl.sv
`default_nettype none
module gfpt_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire gfpt_pkg::t_ctrl_sts i_sts,
    output gfpt_pkg::t_ctrl_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SQUARE = 2'd1;
    localparam logic [1:0] S_ROOT   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    localparam logic [gfpt_pkg::STEP_BITS-1:0] LAST_STEP =
        gfpt_pkg::STEP_BITS'(gfpt_pkg::ACCEL_BITS - 1);

    logic [1:0]                    r_state, n_state;
    logic [gfpt_pkg::STEP_BITS-1:0] r_step, n_step;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.quick ? S_FINISH : S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_step       = '0;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule
`default_nettype wire

// File: sv/gfpt_dp.sv
`default_nettype none
module gfpt_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gfpt_pkg::t_in_word  i_word,
    input  wire logic                i_stall,
    output logic                     o_valid,
    output gfpt_pkg::t_out_word      o_word,
    input  wire gfpt_pkg::t_ctrl_cmd i_cmd,
    output gfpt_pkg::t_ctrl_sts      o_sts
);

    localparam int A = gfpt_pkg::ACCEL_BITS;
    localparam int CB = gfpt_pkg::DOT_CLAMP_BITS;
    localparam int MB = gfpt_pkg::DOT_MULT_BITS;

    // captured sample
    logic                r_mode, r_ok;
    logic                r_x_neg, r_y_neg;
    logic [A-1:0]        r_ax, r_ay;

    // root unit: radicand shifts out two bits per step
    logic [2*A-1:0]      r_sum;
    logic [A+1:0]        r_rem;
    logic [A-1:0]        r_root;

    // peak hold
    logic [A-1:0]        r_tot, r_left, r_right, r_brake;
    logic [A-1:0]        n_tot, n_left, n_right, n_brake;

    logic                r_out_valid;
    gfpt_pkg::t_out_word r_out, n_out;

    logic [A-1:0]        in_ax, in_ay;
    logic [2*A-1:0]      sq_x, sq_y;
    logic [A+3:0]        rem_sh, trial, rem_diff;
    logic                take;
    logic signed [7:0]   mag_x, mag_y;

    function automatic logic [A-1:0] abs_of(input logic [A-1:0] v);
        return v[A-1] ? (~v + 1'b1) : v;
    endfunction

    // floor(min(a,150) * 67 / 150)
    function automatic logic signed [7:0] dot_mag(input logic [A-1:0] a);
        logic [CB-1:0] c;
        logic [MB-1:0] p;
        c = (a > A'(gfpt_pkg::DOT_LIMIT)) ? CB'(gfpt_pkg::DOT_LIMIT) : a[CB-1:0];
        p = MB'(c) * MB'(gfpt_pkg::DOT_RECIP);
        return 8'(p >> gfpt_pkg::DOT_SHIFT);
    endfunction

    function automatic logic [11:0] sat12(input logic [A-1:0] v);
        return (v > A'(12'hFFF)) ? 12'hFFF : v[11:0];
    endfunction

    function automatic logic [10:0] sat11(input logic [A-1:0] v);
        return (v > A'(11'h7FF)) ? 11'h7FF : v[10:0];
    endfunction

    assign in_ax = abs_of(i_word.accel_x);
    assign in_ay = abs_of(i_word.accel_y);
    assign sq_x  = {{A{1'b0}}, r_ax} * {{A{1'b0}}, r_ax};
    assign sq_y  = {{A{1'b0}}, r_ay} * {{A{1'b0}}, r_ay};

    assign rem_sh   = {r_rem, r_sum[2*A-1 -: 2]};
    assign trial    = {2'b00, r_root, 2'b01};
    assign take     = (rem_sh >= trial);
    assign rem_diff = rem_sh - trial;

    assign o_sts.quick    = i_word.mode | ~i_word.sample_ok;
    assign o_sts.out_free = ~r_out_valid | ~i_stall;

    assign mag_x = dot_mag(r_ax);
    assign mag_y = dot_mag(r_ay);

    always_comb begin
        n_tot   = r_tot;
        n_left  = r_left;
        n_right = r_right;
        n_brake = r_brake;
        n_out   = '0;
        priority if (r_mode) begin
            n_tot            = '0;
            n_left           = '0;
            n_right          = '0;
            n_brake          = '0;
            n_out.data_valid = 1'b1;
        end else if (!r_ok) begin
            n_out.data_valid = 1'b0;
        end else begin
            if (r_root > r_tot)                n_tot   = r_root;
            if (r_x_neg && r_ax > r_left)      n_left  = r_ax;
            if (!r_x_neg && r_ax != '0 && r_ax > r_right) n_right = r_ax;
            if (r_y_neg && r_ay > r_brake)     n_brake = r_ay;
            n_out.data_valid = 1'b1;
            n_out.peak_total = sat12(n_tot);
            n_out.peak_left  = sat12(n_left);
            n_out.peak_right = sat11(n_right);
            n_out.peak_brake = sat12(n_brake);
            n_out.dot_x      = r_x_neg ? -mag_x : mag_x;
            n_out.dot_y      = r_y_neg ? mag_y : -mag_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_word.mode;
            r_ok    <= i_word.sample_ok;
            r_x_neg <= i_word.accel_x[A-1];
            r_y_neg <= i_word.accel_y[A-1];
            r_ax    <= in_ax;
            r_ay    <= in_ay;
        end
        if (i_cmd.square) begin
            r_sum  <= sq_x + sq_y;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_sum  <= {r_sum[2*A-3:0], 2'b00};
            r_rem  <= take ? rem_diff[A+1:0] : rem_sh[A+1:0];
            r_root <= {r_root[A-2:0], take};
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot       <= '0;
            r_left      <= '0;
            r_right     <= '0;
            r_brake     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_tot   <= n_tot;
                r_left  <= n_left;
                r_right <= n_right;
                r_brake <= n_brake;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule
`default_nettype wire

// File: sv/gforce_peak_tracker.sv
`default_nettype none
// G-force peak tracker. Each input word carries one lateral (x) and one
// longitudinal (y) acceleration sample in hundredths of g plus a mode bit and
// a sensor-ok bit; each accepted word yields exactly one output word. In normal
// mode the block takes floor(sqrt(x*x + y*y)) as total magnitude and updates
// four peak-hold registers: total, left (x < 0), right (x > 0) and braking
// (y < 0). It also reports an indicator position: each axis clamped to +/-150,
// scaled by 67/150 truncating toward zero, with y negated. Mode = 1 zeroes all
// peaks and returns a valid word of zeros. A failed read (sample_ok = 0) leaves
// the peaks alone and returns data_valid = 0 with all other fields zero.
// Timing: a normal sample passes through the capture cycle that ends at the
// accepting edge, a squaring step, 12 root iterations that retire one result
// bit each on a shared compare/subtract, and an update step that registers its
// output word; the next word can be taken only after that update. Clear and
// failed-read words go from capture straight to the update step. One word is
// in flight at a time; a finished word waits in the output register while the
// next is accepted, and the update step holds only if that register is still
// full and stalled.
module gforce_peak_tracker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // sample channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire gfpt_pkg::t_in_word i_word,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output gfpt_pkg::t_out_word     o_word
);

    gfpt_pkg::t_ctrl_cmd cmd;
    gfpt_pkg::t_ctrl_sts sts;

    // sequencing: capture, square, root iterations, peak update
    gfpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // magnitude, peak hold, indicator scaling and the output register
    gfpt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_word),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_word  (o_word),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule
`default_nettype wire
